/* rtl/ces_pkg.sv */
// ----------------------------------------------------------------------------
// ces_pkg
// Types, constants and the month table shared by the calendar to epoch
// seconds converter.
// ----------------------------------------------------------------------------
package ces_pkg;

	localparam int YEAR_W   = 12;
	localparam int QUOT_W   = 5;
	localparam int PROD_W   = 25;
	localparam int LEAPS_W  = 8;
	localparam int DBM_W    = 9;
	localparam int DAYS_W   = 19;
	localparam int HMS_W    = 17;
	localparam int SEC_W    = 35;

	localparam logic [YEAR_W-1:0] BASE_YEAR  = 12'd1900;
	localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
	localparam logic [9:0]        EPOCH_OFS  = 10'd70;

	// floor(y * 5243 / 2^19) equals floor(y / 100) for every y below 4096.
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	// Gregorian leap years in 1..1969.
	localparam logic [10:0] LEAPS_BEFORE_EPOCH = 11'd477;

	localparam logic [3:0] MONTH_FEB  = 4'd1;
	localparam logic [3:0] MONTH_DEC  = 4'd11;

	localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 19'd365;
	localparam logic [HMS_W-1:0]  SECS_PER_HOUR = 17'd3600;
	localparam logic [HMS_W-1:0]  SECS_PER_MIN  = 17'd60;
	localparam logic [SEC_W-1:0]  SECS_PER_DAY  = 35'd86400;

	typedef struct packed {
		logic [9:0] years_since_1900;
		logic [3:0] month_index;
		logic [4:0] day_of_month;
		logic [4:0] hour_of_day;
		logic [5:0] minute_of_hour;
		logic [5:0] second_of_minute;
	} cal_t;

	typedef struct packed {
		logic              err;
		logic [DAYS_W-1:0] days;
		logic [HMS_W-1:0]  hms;
	} day_t;

	typedef struct packed {
		logic [SEC_W-1:0] epoch_seconds;
		logic             status;
	} res_t;

	function automatic logic [DBM_W-1:0] days_before_month(input logic [3:0] mon);
		logic [DBM_W-1:0] d;
		case (mon)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			default: d = 9'd334;
		endcase
		return d;
	endfunction

endpackage

/* rtl/ces_in_if.sv */
// ----------------------------------------------------------------------------
// ces_in_if
// Valid/ready channel carrying one broken-down calendar date and time.
// ----------------------------------------------------------------------------
interface ces_in_if;
	logic       valid;
	logic       ready;
	logic [9:0] years_since_1900;
	logic [3:0] month_index;
	logic [4:0] day_of_month;
	logic [4:0] hour_of_day;
	logic [5:0] minute_of_hour;
	logic [5:0] second_of_minute;

	modport source (
		output valid, years_since_1900, month_index, day_of_month,
		       hour_of_day, minute_of_hour, second_of_minute,
		input  ready
	);
	modport sink (
		input  valid, years_since_1900, month_index, day_of_month,
		       hour_of_day, minute_of_hour, second_of_minute,
		output ready
	);
endinterface

/* rtl/ces_out_if.sv */
// ----------------------------------------------------------------------------
// ces_out_if
// Valid/ready channel carrying one epoch seconds result and its status.
// ----------------------------------------------------------------------------
interface ces_out_if;
	logic        valid;
	logic        ready;
	logic [34:0] epoch_seconds;
	logic        status;

	modport source (
		output valid, epoch_seconds, status,
		input  ready
	);
	modport sink (
		input  valid, epoch_seconds, status,
		output ready
	);
endinterface

/* rtl/ces_day_count.sv */
// ----------------------------------------------------------------------------
// ces_day_count
// Four pipeline stages that turn a calendar date into a day count since the
// epoch (counting from one) and the seconds within the day.
// ----------------------------------------------------------------------------
module ces_day_count (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ces_pkg::cal_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ces_pkg::day_t   out_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	// Stage 1: year, error flag, month clamp, time of day.
	logic [ces_pkg::YEAR_W-1:0] year_s1;
	logic                       err_s1;
	logic [3:0]                 mon_s1;
	logic [4:0]                 mday_s1;
	logic [ces_pkg::HMS_W-1:0]  hms_s1;

	// Stage 2: quotients by 100 of the year and of the year before.
	logic [ces_pkg::YEAR_W-1:0] year_s2;
	logic                       err_s2;
	logic [3:0]                 mon_s2;
	logic [4:0]                 mday_s2;
	logic [ces_pkg::HMS_W-1:0]  hms_s2;
	logic [ces_pkg::QUOT_W-1:0] qy_s2;
	logic [ces_pkg::QUOT_W-1:0] qp_s2;

	// Stage 3: day terms.
	logic                        err_s3;
	logic [4:0]                  mday_s3;
	logic [ces_pkg::HMS_W-1:0]   hms_s3;
	logic [ces_pkg::LEAPS_W-1:0] leaps_s3;
	logic                        leapday_s3;
	logic [ces_pkg::DAYS_W-1:0]  base_s3;
	logic [ces_pkg::DBM_W-1:0]   dbm_s3;

	// Stage 4: summed day count.
	logic                       err_s4;
	logic [ces_pkg::DAYS_W-1:0] days_s4;
	logic [ces_pkg::HMS_W-1:0]  hms_s4;

	logic [ces_pkg::YEAR_W-1:0] year_c;
	logic [ces_pkg::YEAR_W-1:0] prev_c;
	logic [ces_pkg::PROD_W-1:0] py_c;
	logic [ces_pkg::PROD_W-1:0] pp_c;
	logic [ces_pkg::YEAR_W-1:0] prev_s2_c;
	logic [ces_pkg::YEAR_W-1:0] rem_c;
	logic [10:0]                leaps_c;
	logic                       leap_c;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign year_c = 12'(in_data.years_since_1900) + ces_pkg::BASE_YEAR;
	assign prev_c = year_s1 - 12'd1;
	assign py_c   = 25'(year_s1) * 25'(ces_pkg::RECIP_100);
	assign pp_c   = 25'(prev_c) * 25'(ces_pkg::RECIP_100);

	assign prev_s2_c = year_s2 - 12'd1;
	assign rem_c     = year_s2 - 12'(qy_s2) * 12'd100;
	// Divisible by 4, and either not by 100 or also by 400.
	assign leap_c    = (year_s2[1:0] == 2'd0) && ((rem_c != '0) || (qy_s2[1:0] == 2'd0));
	assign leaps_c   = 11'(prev_s2_c[11:2]) - 11'(qp_s2) + 11'(qp_s2[4:2])
	                 - ces_pkg::LEAPS_BEFORE_EPOCH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			year_s1 <= year_c;
			err_s1  <= in_data.years_since_1900 < ces_pkg::EPOCH_OFS;
			mon_s1  <= (in_data.month_index > ces_pkg::MONTH_DEC) ?
			           ces_pkg::MONTH_DEC : in_data.month_index;
			mday_s1 <= in_data.day_of_month;
			hms_s1  <= 17'(in_data.hour_of_day) * ces_pkg::SECS_PER_HOUR
			         + 17'(in_data.minute_of_hour) * ces_pkg::SECS_PER_MIN
			         + 17'(in_data.second_of_minute);
		end
		if (en_s2 && v_s1) begin
			year_s2 <= year_s1;
			err_s2  <= err_s1;
			mon_s2  <= mon_s1;
			mday_s2 <= mday_s1;
			hms_s2  <= hms_s1;
			qy_s2   <= py_c[ces_pkg::RECIP_SHIFT +: ces_pkg::QUOT_W];
			qp_s2   <= pp_c[ces_pkg::RECIP_SHIFT +: ces_pkg::QUOT_W];
		end
		if (en_s3 && v_s2) begin
			err_s3     <= err_s2;
			mday_s3    <= mday_s2;
			hms_s3     <= hms_s2;
			leaps_s3   <= leaps_c[ces_pkg::LEAPS_W-1:0];
			leapday_s3 <= leap_c && (mon_s2 > ces_pkg::MONTH_FEB);
			base_s3    <= 19'(year_s2 - ces_pkg::EPOCH_YEAR) * ces_pkg::DAYS_PER_YEAR;
			dbm_s3     <= ces_pkg::days_before_month(mon_s2);
		end
		if (en_s4 && v_s3) begin
			err_s4  <= err_s3;
			hms_s4  <= hms_s3;
			days_s4 <= base_s3 + 19'(leaps_s3) + 19'(dbm_s3)
			         + 19'(leapday_s3) + 19'(mday_s3);
		end
	end

	assign out_valid     = v_s4;
	assign out_data.err  = err_s4;
	assign out_data.days = days_s4;
	assign out_data.hms  = hms_s4;

endmodule

/* rtl/ces_sec_scale.sv */
// ----------------------------------------------------------------------------
// ces_sec_scale
// Two pipeline stages: scale the day count to seconds, then add the time of
// day and force the error result.
// ----------------------------------------------------------------------------
module ces_sec_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ces_pkg::day_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ces_pkg::res_t   out_data
);

	logic v_s5, v_s6;
	logic en_s5, en_s6;

	logic                      err_s5;
	logic [ces_pkg::SEC_W-1:0] prod_s5;
	logic [ces_pkg::HMS_W-1:0] hms_s5;

	logic                      err_s6;
	logic [ces_pkg::SEC_W-1:0] total_s6;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign in_ready = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= in_valid;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			err_s5  <= in_data.err;
			hms_s5  <= in_data.hms;
			prod_s5 <= 35'(in_data.days) * ces_pkg::SECS_PER_DAY;
		end
		// Days count from one, so one day comes off; day zero wraps modulo 2^35.
		if (en_s6 && v_s5) begin
			err_s6   <= err_s5;
			total_s6 <= err_s5 ? '0 :
			            prod_s5 - ces_pkg::SECS_PER_DAY + 35'(hms_s5);
		end
	end

	assign out_valid              = v_s6;
	assign out_data.epoch_seconds = total_s6;
	assign out_data.status        = err_s6;

endmodule

/* rtl/calendar_to_epoch_seconds.sv */
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds
// Converts a broken-down UTC date and time into seconds since 1970-01-01.
// ----------------------------------------------------------------------------
// One item enters per clock unless the pipeline is full and stalled: four
// stages form the day count (year and month clamp, quotients by 100 through
// reciprocal multiplies, leap and month terms, the day sum) and two scale it
// to seconds and add the time of day. Each stage holds its item on its own
// when the output stalls, so gaps close up and up to six items are in flight.
// Years before 1970 give status 1 and zero seconds. Fields are not range
// checked; a month index above 11 counts as December.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds (
	input  logic       clk,
	input  logic       arst_n,
	ces_in_if.sink     cal,
	ces_out_if.source  epoch
);

	localparam int          DEPTH    = 6;
	localparam int          OCC_W    = $clog2(DEPTH + 1);
	localparam logic [OCC_W-1:0] DEPTH_C = OCC_W'(DEPTH);

	ces_pkg::cal_t cal_d;
	ces_pkg::day_t day_d;
	ces_pkg::res_t res_d;
	logic          day_valid;
	logic          day_ready;

	assign cal_d.years_since_1900 = cal.years_since_1900;
	assign cal_d.month_index      = cal.month_index;
	assign cal_d.day_of_month     = cal.day_of_month;
	assign cal_d.hour_of_day      = cal.hour_of_day;
	assign cal_d.minute_of_hour   = cal.minute_of_hour;
	assign cal_d.second_of_minute = cal.second_of_minute;

	ces_day_count u_day_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cal.valid),
		.in_ready  (cal.ready),
		.in_data   (cal_d),
		.out_valid (day_valid),
		.out_ready (day_ready),
		.out_data  (day_d)
	);

	ces_sec_scale u_sec_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (day_valid),
		.in_ready  (day_ready),
		.in_data   (day_d),
		.out_valid (epoch.valid),
		.out_ready (epoch.ready),
		.out_data  (res_d)
	);

	assign epoch.epoch_seconds = res_d.epoch_seconds;
	assign epoch.status        = res_d.status;

	// Items in flight, for checking only.
	logic [OCC_W-1:0] occ_q;
	logic             acc_in;
	logic             acc_out;

	assign acc_in  = cal.valid && cal.ready;
	assign acc_out = epoch.valid && epoch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (acc_in && !acc_out) begin
			occ_q <= occ_q + OCC_W'(1);
		end else if (acc_out && !acc_in) begin
			occ_q <= occ_q - OCC_W'(1);
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		epoch.valid && epoch.status |-> epoch.epoch_seconds == '0)
		else $error("error result carries nonzero seconds");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= DEPTH_C)
		else $error("more items in flight than pipeline stages");

	a_out_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		epoch.valid |-> occ_q != '0)
		else $error("result shown with no item in flight");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == DEPTH_C && !epoch.ready |-> !cal.ready)
		else $error("item taken while pipeline is full and stalled");

endmodule
